FILE: rtl/csdt_pkg.sv
`timescale 1ns / 1ps
package csdt_pkg;
    localparam int TableEntries = 16;
    localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam int CntW = $clog2(TableEntries + 1);
    localparam int EntryW = 256;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_RECORD = 2'd1;
    localparam logic [1:0] CMD_BOUNDARY = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] DISP_RETRY = 2'd0;
    localparam logic [1:0] DISP_TOO_OLD = 2'd1;
    localparam logic [1:0] DISP_NEW = 2'd2;
    localparam logic [1:0] DISP_GAP = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_RESPONSE = 3'd1;
    localparam logic [2:0] ST_ID_MISMATCH = 3'd2;
    localparam logic [2:0] ST_RETRY_DIFFERS = 3'd3;
    localparam logic [2:0] ST_GAP = 3'd4;
    localparam logic [2:0] ST_FULL = 3'd5;
    localparam logic [2:0] ST_BEYOND = 3'd6;

    localparam logic [31:0] RespVersionOne = 32'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] session_key;
        logic [63:0] seq_num;
        logic [31:0] resp_version;
        logic        resp_committed;
        logic [63:0] resp_seq_num;
        logic [63:0] resp_term;
        logic [63:0] resp_commit_index;
        logic [63:0] boundary_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  disposition;
        logic        found;
        logic [63:0] last_request;
        logic [63:0] last_term;
        logic [63:0] last_commit;
        logic [2:0]  status;
    } t_rsp;

    function automatic logic [1:0] classify(logic [63:0] req, logic [63:0] last);
        logic [1:0] d;
        if (req == last && req != 64'd0) d = DISP_RETRY;
        else if (req <= last) d = DISP_TOO_OLD;
        else if (req == last + 64'd1) d = DISP_NEW;
        else d = DISP_GAP;
        return d;
    endfunction
endpackage

FILE: rtl/csdt_if.sv
`timescale 1ns / 1ps
interface csdt_req_if;
    logic valid;
    logic ready;
    csdt_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface csdt_rsp_if;
    logic valid;
    logic ready;
    csdt_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/csdt_ram.sv
`timescale 1ns / 1ps
module csdt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/client_session_dedup_table.sv
`timescale 1ns / 1ps
// Client session table of TableEntries sessions held in one synchronous RAM
// (key, last request, term, commit per entry) with valid bits in flops.
// Each transfer is served alone: the sequencer sweeps all TableEntries
// addresses through the RAM read port, one per cycle, then decides and
// optionally writes in S_DONE, and presents the result in S_OUT. The
// result sits in an output register; the next command is accepted the
// cycle after it has been taken.
// Unused command code 3 answers all zero.
module client_session_dedup_table (
    input  logic i_clk,
    input  logic i_rst_n,
    csdt_req_if.sink   i_req,
    csdt_rsp_if.source o_rsp
);
    import csdt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_req r_req;
    t_rsp r_rsp;
    logic [TableEntries-1:0] r_valid;
    logic [CntW-1:0] r_cnt;
    logic [IdxW-1:0] r_ridx;
    logic r_rd_vld;
    logic r_hit, r_beyond;
    logic [IdxW-1:0] r_slot;
    logic [EntryW-1:0] r_ent;
    logic [EntryW-1:0] rdata;
    logic we;
    logic [IdxW-1:0] waddr, free_idx;
    logic free_ok;
    logic [63:0] lst, trm, cmt;
    t_rsp rsp;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.payload = r_rsp;

    csdt_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr),
        .i_wdata({r_req.session_key, r_req.seq_num, r_req.resp_term,
                  r_req.resp_commit_index}),
        .i_raddr(r_ridx), .o_rdata(rdata)
    );

    // lowest free slot: priority over valid bits
    always_comb begin
        free_ok = 1'b0;
        free_idx = '0;
        for (int i = TableEntries - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok = 1'b1;
                free_idx = IdxW'(i);
            end
        end
    end

    // decide the result and the write from scan results
    always_comb begin
        lst = r_hit ? r_ent[191:128] : 64'd0;
        trm = r_hit ? r_ent[127:64] : 64'd0;
        cmt = r_hit ? r_ent[63:0] : 64'd0;
        rsp = '0;
        we = 1'b0;
        waddr = r_hit ? r_slot : free_idx;
        if (r_req.command == CMD_LOOKUP || r_req.command == CMD_RECORD) begin
            rsp.found = r_hit;
            rsp.last_request = lst;
            rsp.last_term = trm;
            rsp.last_commit = cmt;
            rsp.disposition = classify(r_req.seq_num, lst);
            if (r_req.command == CMD_RECORD) begin
                if (r_req.resp_version != RespVersionOne || !r_req.resp_committed
                    || r_req.resp_seq_num == 64'd0
                    || r_req.resp_commit_index == 64'd0) begin
                    rsp.status = ST_BAD_RESPONSE;
                end else if (r_req.session_key == 64'd0 || r_req.seq_num == 64'd0
                    || r_req.resp_seq_num != r_req.seq_num) begin
                    rsp.status = ST_ID_MISMATCH;
                end else if (r_req.seq_num == lst) begin
                    if (trm != r_req.resp_term || cmt != r_req.resp_commit_index)
                        rsp.status = ST_RETRY_DIFFERS;
                end else if (r_req.seq_num != lst + 64'd1) begin
                    rsp.status = ST_GAP;
                end else if (!r_hit && !free_ok) begin
                    rsp.status = ST_FULL;
                end else begin
                    we = (r_state == S_DONE);
                end
            end
        end else if (r_req.command == CMD_BOUNDARY) begin
            rsp.status = r_beyond ? ST_BEYOND : ST_OK;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_SCAN;
            S_SCAN: if (r_cnt == CntW'(TableEntries)) n_state = S_DONE;
            S_DONE: n_state = S_OUT;
            S_OUT:  if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_vld <= (r_state == S_SCAN) && (r_cnt < CntW'(TableEntries));
            if (we) r_valid[waddr] <= 1'b1;
        end
    end

    // sweep addresses and fold read data
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_req <= i_req.payload;
            r_cnt <= '0;
            r_ridx <= '0;
            r_hit <= 1'b0;
            r_beyond <= 1'b0;
        end
        if (r_state == S_SCAN && r_cnt < CntW'(TableEntries)) begin
            r_cnt <= r_cnt + CntW'(1);
            r_ridx <= r_ridx + IdxW'(1);
        end
        if (r_rd_vld && r_valid[r_ridx - IdxW'(1)]) begin
            if (!r_hit && rdata[255:192] == r_req.session_key) begin
                r_hit <= 1'b1;
                r_slot <= r_ridx - IdxW'(1);
                r_ent <= rdata;
            end
            if (rdata[63:0] > r_req.boundary_index) r_beyond <= 1'b1;
        end
        if (r_state == S_DONE) r_rsp <= rsp;
    end
endmodule

FILE: dv/client_session_dedup_table_test.sv
`timescale 1ns / 1ps
module client_session_dedup_table_test;
    import csdt_pkg::*;

    localparam int NumClients = 24;

    // Holds the session table as the block should hold it, plus the queue of
    // answers still owed by the block.
    class session_table_sb;
        bit          valid_q [TableEntries];
        logic [63:0] key_q [TableEntries];
        logic [63:0] last_q [TableEntries];
        logic [63:0] term_q [TableEntries];
        logic [63:0] commit_q [TableEntries];
        t_rsp        owed_q[$];
        int          errors;

        function void clear();
            foreach (valid_q[i]) valid_q[i] = 0;
            owed_q.delete();
            errors = 0;
        endfunction

        // Work out the answer to one accepted command and update the table.
        function void note_command(t_req r);
            t_rsp        a;
            int          slot;
            logic [63:0] last;
            a = '0;
            a.status = ST_OK;
            slot = -1;
            if (r.command == CMD_LOOKUP || r.command == CMD_RECORD) begin
                for (int i = 0; i < TableEntries; i++)
                    if (slot < 0 && valid_q[i] && key_q[i] == r.session_key) slot = i;
                if (slot >= 0) begin
                    a.found = 1'b1;
                    a.last_request = last_q[slot];
                    a.last_term = term_q[slot];
                    a.last_commit = commit_q[slot];
                end
                last = a.last_request;
                if (r.seq_num == last && r.seq_num != 0) a.disposition = DISP_RETRY;
                else if (r.seq_num <= last) a.disposition = DISP_TOO_OLD;
                else if (r.seq_num == last + 64'd1) a.disposition = DISP_NEW;
                else a.disposition = DISP_GAP;
                if (r.command == CMD_RECORD) begin
                    if (r.resp_version != RespVersionOne || !r.resp_committed ||
                        r.resp_seq_num == 0 || r.resp_commit_index == 0) begin
                        a.status = ST_BAD_RESPONSE;
                    end else if (r.session_key == 0 || r.seq_num == 0 ||
                                 r.resp_seq_num != r.seq_num) begin
                        a.status = ST_ID_MISMATCH;
                    end else if (r.seq_num == last) begin
                        if (a.last_term != r.resp_term || a.last_commit != r.resp_commit_index)
                            a.status = ST_RETRY_DIFFERS;
                    end else if (r.seq_num != last + 64'd1) begin
                        a.status = ST_GAP;
                    end else begin
                        if (slot < 0)
                            for (int i = 0; i < TableEntries; i++)
                                if (slot < 0 && !valid_q[i]) slot = i;
                        if (slot < 0) begin
                            a.status = ST_FULL;
                        end else begin
                            valid_q[slot] = 1'b1;
                            key_q[slot] = r.session_key;
                            last_q[slot] = r.seq_num;
                            term_q[slot] = r.resp_term;
                            commit_q[slot] = r.resp_commit_index;
                        end
                    end
                end
            end else if (r.command == CMD_BOUNDARY) begin
                for (int i = 0; i < TableEntries; i++)
                    if (valid_q[i] && commit_q[i] > r.boundary_index) a.status = ST_BEYOND;
            end
            owed_q.push_back(a);
        endfunction

        function void check_answer(t_rsp got);
            t_rsp want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected answer %h", $time, got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.disposition !== want.disposition)
                $display("%0t: disposition exp %0d act %0d", $time, want.disposition,
                         got.disposition);
            if (got.found !== want.found)
                $display("%0t: found exp %0d act %0d", $time, want.found, got.found);
            if (got.last_request !== want.last_request)
                $display("%0t: last_request exp %h act %h", $time, want.last_request,
                         got.last_request);
            if (got.last_term !== want.last_term)
                $display("%0t: last_term exp %h act %h", $time, want.last_term, got.last_term);
            if (got.last_commit !== want.last_commit)
                $display("%0t: last_commit exp %h act %h", $time, want.last_commit,
                         got.last_commit);
            if (got.status !== want.status)
                $display("%0t: status exp %0d act %0d", $time, want.status, got.status);
            if (got !== want) errors++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    csdt_req_if req_ch ();
    csdt_rsp_if rsp_ch ();
    session_table_sb sb;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic [63:0] client_pool [NumClients];
    logic [63:0] next_req [NumClients];
    logic [63:0] saved_term [NumClients];
    logic [63:0] saved_commit [NumClients];

    client_session_dedup_table uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        sb = new();
        sb.clear();
    end

    // Note accepted commands and check answers at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) sb.note_command(req_ch.payload);
            if (rsp_ch.valid && rsp_ch.ready) sb.check_answer(rsp_ch.payload);
        end
    end

    // Stall the answer channel at random.
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Drive one command, with a random gap first, and hold it until taken.
    // Valid is left high after the transfer; the next gap or drain drops it.
    task automatic send_command(t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    function automatic t_req good_record(logic [63:0] cid, logic [63:0] rid,
                                         logic [63:0] trm, logic [63:0] cmt);
        t_req r;
        r = '0;
        r.command = CMD_RECORD;
        r.session_key = cid;
        r.seq_num = rid;
        r.resp_seq_num = rid;
        r.resp_version = RespVersionOne;
        r.resp_committed = 1'b1;
        r.resp_term = trm;
        r.resp_commit_index = cmt;
        r.boundary_index = rand64();
        return r;
    endfunction

    // Mostly well-formed session traffic over a small client pool, with noise.
    task automatic random_command();
        t_req         r;
        int           c;
        int           pick;
        logic [447:0] noise;
        c = $urandom_range(NumClients - 1);
        pick = $urandom_range(99);
        if (pick < 45) begin
            if ($urandom_range(3) == 0) begin
                r = good_record(client_pool[c], next_req[c] - 1, saved_term[c], saved_commit[c]);
                if ($urandom_range(1)) r.resp_term ^= 64'd1 << $urandom_range(63);
            end else begin
                r = good_record(client_pool[c], next_req[c], rand64(), rand64() | 64'd1);
            end
            if ($urandom_range(9) == 0) r.resp_version = $urandom;
            if ($urandom_range(9) == 0) r.resp_committed = 1'b0;
            if ($urandom_range(15) == 0) r.resp_seq_num = rand64();
            if ($urandom_range(15) == 0) begin
                r.seq_num = next_req[c] + $urandom_range(5);
                r.resp_seq_num = r.seq_num;
            end
            if (r.seq_num == next_req[c] && r.resp_version == RespVersionOne &&
                r.resp_committed && r.resp_seq_num == r.seq_num) begin
                saved_term[c] = r.resp_term;
                saved_commit[c] = r.resp_commit_index;
                next_req[c] = next_req[c] + 1;
            end
        end else if (pick < 75) begin
            r = '0;
            r.command = CMD_LOOKUP;
            r.session_key = client_pool[c];
            r.seq_num = next_req[c] + $urandom_range(4) - 2;
            if ($urandom_range(7) == 0) r.seq_num = rand64();
        end else if (pick < 88) begin
            r = '0;
            r.command = CMD_BOUNDARY;
            r.boundary_index = $urandom_range(1) ? rand64() : {32'd0, $urandom};
        end else begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            r = noise[$bits(t_req)-1:0];
        end
        send_command(r);
    endtask

    // Drop valid and wait until every owed answer has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_req r;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, every error class, a full table and boundaries.
        r = '0;
        r.command = CMD_LOOKUP;
        r.seq_num = 64'd0;
        send_command(r);
        r.seq_num = '1;
        send_command(r);
        r.command = CMD_UNUSED;
        r.session_key = '1;
        send_command(r);
        r = good_record(64'd7, 64'd1, 64'd3, 64'd5);
        r.resp_version = 32'hFFFF_FFFF;
        send_command(r);
        r = good_record(64'd7, 64'd1, 64'd3, 64'd0);
        send_command(r);
        r = good_record(64'd0, 64'd1, 64'd3, 64'd5);
        send_command(r);
        r = good_record(64'd7, 64'd1, 64'd3, 64'd5);
        r.resp_seq_num = 64'd2;
        send_command(r);
        send_command(good_record(64'd7, 64'd3, 64'd3, 64'd5));
        for (int i = 0; i < TableEntries; i++)
            send_command(good_record(i == 0 ? '1 : 64'd100 + 64'(i), 64'd1, '1,
                                     i == 0 ? '1 : 64'(i)));
        send_command(good_record(64'd999, 64'd1, 64'd1, 64'd1));
        send_command(good_record('1, 64'd1, '1, '1));
        send_command(good_record('1, 64'd1, '1, 64'd4));
        send_command(good_record('1, 64'd2, 64'd0, 64'd1));
        r = '0;
        r.command = CMD_BOUNDARY;
        r.boundary_index = '1;
        send_command(r);
        r.boundary_index = 64'd0;
        send_command(r);
        wait_drained();

        // A fresh table is not possible without reset; use a pool that reuses
        // the directed keys so records still land.
        for (int i = 0; i < NumClients; i++) begin
            client_pool[i] = (i < TableEntries) ? (i == 0 ? '1 : 64'd100 + 64'(i)) : rand64();
            next_req[i] = (i < TableEntries) ? (i == 0 ? 64'd3 : 64'd2) : 64'd1;
            saved_term[i] = '1;
            saved_commit[i] = (i == 0) ? 64'd1 : 64'(i);
        end
        saved_term[0] = 64'd0;

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 82 : 34) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 82 : 34) : 0;
            for (int n = 0; n < 470; n++) begin
                random_command();
                if (n == 200) wait_drained();
            end
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
